// File: rtl/event_dedup_window_table_unit_assert.svh
// Assertion macros for the duplicate suppression table checker.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef EVENT_DEDUP_WINDOW_TABLE_UNIT_ASSERT_SVH
`define EVENT_DEDUP_WINDOW_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define EDW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define EDW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/edw_pkg.sv
// Shared types and constants for the duplicate suppression table.
// No dependencies; imported by the top level and the checker.
package edw_pkg;

    localparam int PID_W       = 32;
    localparam int OP_W        = 8;
    localparam int HASH_W      = 32;
    localparam int TICK_W      = 63;
    localparam int SLOT_USED_W = 7;

    // Window length after reset: ten seconds in 100 ns ticks.
    localparam logic [TICK_W-1:0] WINDOW_RESET = 63'd100000000;

    // One table entry as held in memory.
    typedef struct packed {
        logic              vld;
        logic [PID_W-1:0]  pid;
        logic [OP_W-1:0]   op;
        logic [HASH_W-1:0] hash;
        logic [TICK_W-1:0] ts;
    } t_entry;

endpackage

// File: rtl/edw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module edw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/event_dedup_window_table_unit.sv
// Duplicate event suppression table: one item at a time, scanned out of one memory.
// Each item scans the slots in order, and a key match ends the scan early. The scan
// reads one slot a cycle through the one read port.
// After reset a clearing pass writes every slot, with the input stalled.
// Depends on edw_pkg and edw_ram.
module event_dedup_window_table_unit import edw_pkg::*; #(
    parameter int SLOTS = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [TICK_W-1:0]      i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PID_W-1:0]       i_proc_id,
    input  logic [OP_W-1:0]        i_op_code,
    input  logic [HASH_W-1:0]      i_key_hash,
    input  logic [TICK_W-1:0]      i_now_ticks,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_suppressed,
    output logic [SLOT_USED_W-1:0] o_slot_used,
    output logic                   o_evicted_valid
);

    localparam int            IW   = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]        r_state,     n_state;
    logic [TICK_W-1:0] r_window,    n_window;
    logic [PID_W-1:0]  r_pid,       n_pid;
    logic [OP_W-1:0]   r_op,        n_op;
    logic [HASH_W-1:0] r_hash,      n_hash;
    logic [TICK_W-1:0] r_now,       n_now;
    logic [IW-1:0]     r_rd_addr,   n_rd_addr;
    logic              r_issue_on,  n_issue_on;
    logic              r_chk_vld,   n_chk_vld;
    logic [IW-1:0]     r_chk_idx,   n_chk_idx;
    logic              r_have_inv,  n_have_inv;
    logic              r_have_old,  n_have_old;
    logic [TICK_W-1:0] r_oldest,    n_oldest;
    logic [IW-1:0]     r_pick,      n_pick;
    logic              r_pick_vld,  n_pick_vld;
    logic              r_suppr,     n_suppr;
    logic              r_evict,     n_evict;
    logic              r_out_vld,   n_out_vld;
    logic              r_out_suppr, n_out_suppr;
    logic [IW-1:0]     r_out_slot,  n_out_slot;
    logic              r_out_evict, n_out_evict;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    t_entry            ram_rdata;
    logic              key_hit;
    logic              in_win;
    logic [TICK_W-1:0] age;

    edw_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    // Key and window checks on the entry read back this cycle.
    always_comb begin
        key_hit = ram_rdata.vld && (ram_rdata.pid == r_pid) && (ram_rdata.op == r_op)
                  && (ram_rdata.hash == r_hash);
        age     = r_now - ram_rdata.ts;
        in_win  = (r_now >= ram_rdata.ts) && (age <= r_window);
    end

    // Sequencer: clearing pass, scan with a registered read, write-back.
    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_pid       = r_pid;
        n_op        = r_op;
        n_hash      = r_hash;
        n_now       = r_now;
        n_rd_addr   = r_rd_addr;
        n_issue_on  = r_issue_on;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_have_inv  = r_have_inv;
        n_have_old  = r_have_old;
        n_oldest    = r_oldest;
        n_pick      = r_pick;
        n_pick_vld  = r_pick_vld;
        n_suppr     = r_suppr;
        n_evict     = r_evict;
        n_out_vld   = r_out_vld;
        n_out_suppr = r_out_suppr;
        n_out_slot  = r_out_slot;
        n_out_evict = r_out_evict;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_pick;
        ram_wdata   = '{vld: 1'b1, pid: r_pid, op: r_op, hash: r_hash, ts: r_now};

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        if (i_cfg_we) begin
            n_window = i_cfg_wdata;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_rd_addr;
                ram_wdata = '0;
                n_rd_addr = r_rd_addr + 1'b1;
                if (r_rd_addr == LAST) begin
                    n_rd_addr = '0;
                    n_state   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_pid      = i_proc_id;
                    n_op       = i_op_code;
                    n_hash     = i_key_hash;
                    n_now      = i_now_ticks;
                    n_rd_addr  = '0;
                    n_issue_on = 1'b1;
                    n_chk_vld  = 1'b0;
                    n_have_inv = 1'b0;
                    n_have_old = 1'b0;
                    n_pick     = '0;
                    n_pick_vld = 1'b0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the next slot read.
                n_chk_vld = r_issue_on;
                if (r_issue_on) begin
                    ram_re    = 1'b1;
                    n_chk_idx = r_rd_addr;
                    n_rd_addr = r_rd_addr + 1'b1;
                    if (r_rd_addr == LAST) begin
                        n_issue_on = 1'b0;
                    end
                end
                // Judge the slot whose data has come back.
                if (r_chk_vld) begin
                    if (!ram_rdata.vld) begin
                        n_pick     = r_chk_idx;
                        n_pick_vld = 1'b0;
                        n_have_inv = 1'b1;
                    end else if (!r_have_inv && (!r_have_old || ram_rdata.ts < r_oldest)) begin
                        n_oldest   = ram_rdata.ts;
                        n_have_old = 1'b1;
                        n_pick     = r_chk_idx;
                        n_pick_vld = 1'b1;
                    end
                    if (key_hit) begin
                        n_pick     = r_chk_idx;
                        n_suppr    = in_win;
                        n_evict    = 1'b0;
                        n_issue_on = 1'b0;
                        n_chk_vld  = 1'b0;
                        n_state    = ST_WRITE;
                    end else if (r_chk_idx == LAST) begin
                        n_suppr    = 1'b0;
                        n_evict    = n_pick_vld;
                        n_issue_on = 1'b0;
                        n_chk_vld  = 1'b0;
                        n_state    = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                // Write back the chosen slot once the result register is free.
                if (!r_out_vld || !i_out_stall) begin
                    ram_we      = 1'b1;
                    n_out_vld   = 1'b1;
                    n_out_suppr = r_suppr;
                    n_out_slot  = r_pick;
                    n_out_evict = r_evict;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State registers; payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_window   <= WINDOW_RESET;
            r_rd_addr  <= '0;
            r_issue_on <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_window   <= n_window;
            r_rd_addr  <= n_rd_addr;
            r_issue_on <= n_issue_on;
            r_chk_vld  <= n_chk_vld;
            r_out_vld  <= n_out_vld;
        end
        r_pid       <= n_pid;
        r_op        <= n_op;
        r_hash      <= n_hash;
        r_now       <= n_now;
        r_chk_idx   <= n_chk_idx;
        r_have_inv  <= n_have_inv;
        r_have_old  <= n_have_old;
        r_oldest    <= n_oldest;
        r_pick      <= n_pick;
        r_pick_vld  <= n_pick_vld;
        r_suppr     <= n_suppr;
        r_evict     <= n_evict;
        r_out_suppr <= n_out_suppr;
        r_out_slot  <= n_out_slot;
        r_out_evict <= n_out_evict;
    end

    // Ports.
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_suppressed    = r_out_suppr;
    assign o_slot_used     = SLOT_USED_W'(r_out_slot);
    assign o_evicted_valid = r_out_evict;

endmodule

// File: rtl/edw_checker.sv
// Port-level checker for the duplicate suppression table, with its bind.
// Depends on edw_pkg and event_dedup_window_table_unit_assert.svh.
`include "event_dedup_window_table_unit_assert.svh"

module edw_checker import edw_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic                   o_suppressed,
    input logic [SLOT_USED_W-1:0] o_slot_used,
    input logic                   o_evicted_valid
);

    // A waiting result stays offered and its slot stays unchanged.
    `EDW_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result item dropped while stalled")
    `EDW_ASSERT_NXT(a_slot_hold, o_out_valid && i_out_stall, $stable(o_slot_used), "slot changed while stalled")

    // A suppressed item never reports an eviction.
    `EDW_ASSERT_IMP(a_supp_no_evict, o_out_valid && o_suppressed, !o_evicted_valid, "suppressed item reports eviction")

    // The table is being cleared when reset is released.
    `EDW_ASSERT_IMP(a_clear_after_reset, $rose(i_rst_n), o_in_stall, "item accepted during clearing pass")

    // An accepted item occupies the block for at least the next cycle.
    `EDW_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "second item accepted too soon")

endmodule

bind event_dedup_window_table_unit edw_checker u_edw_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the duplicate event suppression table.
// A directed table of events runs first, then random phases under several window lengths.
// Depends on edw_pkg and event_dedup_window_table_unit.
`timescale 1ns / 100ps

module tb_top;
    import edw_pkg::*;

    localparam int NSLOTS = 128;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_EVENTS = 140;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // One result of the table: what the block reports for an event.
    typedef struct packed {
        logic                   suppressed;
        logic [SLOT_USED_W-1:0] slot;
        logic                   evicted;
    } t_verdict;

    // Event key as kept in the random key pool.
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [OP_W-1:0]   op;
        logic [HASH_W-1:0] hash;
    } t_key;

    // One row of the directed table; typed rows carry a hand-worked result.
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [OP_W-1:0]   op;
        logic [HASH_W-1:0] hash;
        logic [TICK_W-1:0] now;
        logic              typed;
        t_verdict          want;
    } t_probe;

    localparam t_probe PROBES [15] = '{
        // First event after reset lands in the last free slot.
        '{32'h0, 8'h00, 32'h0, 63'd0, 1'b1, '{1'b0, 7'd127, 1'b0}},
        // Same key at the same time is a duplicate.
        '{32'h0, 8'h00, 32'h0, 63'd0, 1'b1, '{1'b1, 7'd127, 1'b0}},
        // All-ones key takes the next free slot down.
        '{32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, WINDOW_RESET, 1'b1, '{1'b0, 7'd126, 1'b0}},
        // Exactly one window after last seen is still a duplicate.
        '{32'h0, 8'h00, 32'h0, WINDOW_RESET, 1'b1, '{1'b1, 7'd127, 1'b0}},
        // One tick past the window rewrites the matching slot.
        '{32'h0, 8'h00, 32'h0, WINDOW_RESET * 2 + 63'd1, 1'b1, '{1'b0, 7'd127, 1'b0}},
        // A time before last seen counts as outside the window.
        '{32'h0, 8'h00, 32'h0, 63'd5, 1'b1, '{1'b0, 7'd127, 1'b0}},
        // Largest time, far outside the window.
        '{32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, TICK_MAX, 1'b1, '{1'b0, 7'd126, 1'b0}},
        '{32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, TICK_MAX, 1'b1, '{1'b1, 7'd126, 1'b0}},
        // Alternating bit patterns in every field.
        '{32'hA5A5_A5A5, 8'h5A, 32'h5A5A_5A5A, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1,
          '{1'b0, 7'd125, 1'b0}},
        '{32'h5A5A_5A5A, 8'hA5, 32'hA5A5_A5A5, 63'h5555_5555_5555_5555, 1'b1,
          '{1'b0, 7'd124, 1'b0}},
        // Keys that differ from an existing one in a single field.
        '{32'h0, 8'h01, 32'h0, 63'd6, 1'b0, '0},
        '{32'h0, 8'h00, 32'h1, 63'd6, 1'b0, '0},
        '{32'h1, 8'h00, 32'h0, 63'd6, 1'b0, '0},
        // Window edge measured from an earlier rewrite.
        '{32'h0, 8'h00, 32'h0, WINDOW_RESET + 63'd5, 1'b0, '0},
        '{32'hA5A5_A5A5, 8'h5A, 32'h5A5A_5A5A, 63'h2AAA_AAAA_AAAA_AAAA + WINDOW_RESET + 63'd1,
          1'b0, '0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [TICK_W-1:0]      cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic [PID_W-1:0]       proc_id;
    logic [OP_W-1:0]        op_code;
    logic [HASH_W-1:0]      key_hash;
    logic [TICK_W-1:0]      now_ticks;
    logic                   out_valid;
    logic                   out_stall;
    logic                   suppressed;
    logic [SLOT_USED_W-1:0] slot_used;
    logic                   evicted_valid;

    // Shadow copy of the slot table and the window register.
    t_entry            shadow_tbl [NSLOTS];
    logic [TICK_W-1:0] window_ticks;
    t_verdict          pending_verdicts [$];

    int send_calm;
    int recv_calm;
    int events_sent;
    int results_seen;
    int suppressed_seen;
    int evicted_seen;
    int window_settings;
    int mismatches;
    int cycle_count;

    event_dedup_window_table_unit #(
        .SLOTS(NSLOTS)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_proc_id      (proc_id),
        .i_op_code      (op_code),
        .i_key_hash     (key_hash),
        .i_now_ticks    (now_ticks),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_suppressed   (suppressed),
        .o_slot_used    (slot_used),
        .o_evicted_valid(evicted_valid)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL event_dedup_window_table_unit");
            $finish;
        end
    end

    // Scan the shadow table as the block does and apply the update.
    function automatic t_verdict dedup_lookup(input logic [PID_W-1:0] pid,
                                              input logic [OP_W-1:0] op,
                                              input logic [HASH_W-1:0] hash,
                                              input logic [TICK_W-1:0] now);
        int unsigned       pick;
        bit                seen_free;
        bit                seen_live;
        bit                hit;
        logic [TICK_W-1:0] oldest;
        t_verdict          v;
        pick = 0;
        seen_free = 1'b0;
        seen_live = 1'b0;
        hit = 1'b0;
        oldest = '0;
        v = '0;
        for (int i = 0; i < NSLOTS; i++) begin
            if (!shadow_tbl[i].vld) begin
                pick = i;
                seen_free = 1'b1;
                continue;
            end
            // Oldest live slot counts only while no free slot has been seen.
            if (!seen_free && (!seen_live || shadow_tbl[i].ts < oldest)) begin
                oldest = shadow_tbl[i].ts;
                seen_live = 1'b1;
                pick = i;
            end
            if (shadow_tbl[i].pid == pid && shadow_tbl[i].op == op &&
                shadow_tbl[i].hash == hash) begin
                if (now >= shadow_tbl[i].ts && now - shadow_tbl[i].ts <= window_ticks) begin
                    shadow_tbl[i].ts = now;
                    v.suppressed = 1'b1;
                    v.slot = i[SLOT_USED_W-1:0];
                    return v;
                end
                pick = i;
                hit = 1'b1;
                break;
            end
        end
        v.slot = pick[SLOT_USED_W-1:0];
        v.evicted = !hit && shadow_tbl[pick].vld;
        shadow_tbl[pick] = '{1'b1, pid, op, hash, now};
        return v;
    endfunction

    // Wait in cycles for one item, with occasional runs of no waiting at all.
    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic logic [TICK_W-1:0] rand_ticks();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TICK_W-1:0];
    endfunction

    // Present one event and record its expected result once accepted.
    task automatic offer_event(input logic [PID_W-1:0] pid, input logic [OP_W-1:0] op,
                               input logic [HASH_W-1:0] hash, input logic [TICK_W-1:0] now,
                               input logic typed, input t_verdict want);
        int       gap;
        t_verdict predicted;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        proc_id   <= pid;
        op_code   <= op;
        key_hash  <= hash;
        now_ticks <= now;
        do @(posedge clk); while (in_stall);
        predicted = dedup_lookup(pid, op, hash, now);
        pending_verdicts.push_back(typed ? want : predicted);
        events_sent++;
    endtask

    // Drain every outstanding result, then write a new window length.
    task automatic set_window(input logic [TICK_W-1:0] w);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_ticks = w;
        window_settings++;
    endtask

    // Result side: random stall per item, then compare with the oldest expectation.
    initial begin
        int       hold;
        t_verdict want;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            hold = draw_wait(recv_calm);
            if (hold > 0) begin
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (hold - 1) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (suppressed) suppressed_seen++;
            if (evicted_valid) evicted_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: suppressed=%0b slot=%0d evicted=%0b",
                             suppressed, slot_used, evicted_valid);
            end else begin
                want = pending_verdicts.pop_front();
                if (suppressed !== want.suppressed || slot_used !== want.slot ||
                    evicted_valid !== want.evicted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch on result %0d: expected suppressed=%0b slot=%0d ",
                                  "evicted=%0b, got suppressed=%0b slot=%0d evicted=%0b"},
                                 results_seen, want.suppressed, want.slot, want.evicted,
                                 suppressed, slot_used, evicted_valid);
                end
            end
        end
    end

    // Event side: reset, directed table, then random phases under several windows.
    initial begin
        logic [TICK_W-1:0] plan [6];
        logic [TICK_W-1:0] cur;
        logic [TICK_W-1:0] scale;
        logic [TICK_W-1:0] now;
        t_key              key_pool [48];
        t_key              k;
        int                pick;
        int                r;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        proc_id   <= '0;
        op_code   <= '0;
        key_hash  <= '0;
        now_ticks <= '0;
        cycle_count = 0;
        send_calm = 0;
        recv_calm = 0;
        events_sent = 0;
        results_seen = 0;
        suppressed_seen = 0;
        evicted_seen = 0;
        window_settings = 0;
        mismatches = 0;
        window_ticks = WINDOW_RESET;
        for (int i = 0; i < NSLOTS; i++) shadow_tbl[i] = '0;
        for (int i = 0; i < 48; i++) key_pool[i] = {$urandom, $urandom, 8'($urandom)};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed events under the window left by reset.
        for (int i = 0; i < $size(PROBES); i++)
            offer_event(PROBES[i].pid, PROBES[i].op, PROBES[i].hash, PROBES[i].now,
                        PROBES[i].typed, PROBES[i].want);

        plan = '{63'd0, 63'd1000, TICK_MAX, rand_ticks(), 63'd37, WINDOW_RESET};
        foreach (plan[p]) begin
            set_window(plan[p]);
            cur = (p % 2 == 1) ? rand_ticks() : TICK_W'($urandom_range(0, 1000));
            scale = (plan[p] > 63'd8_000_000_000) ? (63'd1 << 30) : plan[p] / 8 + 63'd1;
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                // Mostly keys from the pool, some fresh ones, some near misses.
                r = $urandom_range(0, 99);
                pick = $urandom_range(0, 47);
                k = key_pool[pick];
                if (r < 30) begin
                    k = {$urandom, $urandom, 8'($urandom)};
                    key_pool[pick] = k;
                end else if (r < 36) begin
                    case ($urandom_range(0, 2))
                        0: k.pid[$urandom_range(0, PID_W - 1)] ^= 1'b1;
                        1: k.op[$urandom_range(0, OP_W - 1)] ^= 1'b1;
                        default: k.hash[$urandom_range(0, HASH_W - 1)] ^= 1'b1;
                    endcase
                end

                // Time mostly moves forward at a pace set by the window.
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    now = cur;
                end else if (r < 60) begin
                    cur = cur + TICK_W'($urandom_range(0, 32'(scale)));
                    now = cur;
                end else if (r < 70) begin
                    // Land on the window edge of the key's last sighting, or one past.
                    now = cur;
                    for (int i = 0; i < NSLOTS; i++)
                        if (shadow_tbl[i].vld && shadow_tbl[i].pid == k.pid &&
                            shadow_tbl[i].op == k.op && shadow_tbl[i].hash == k.hash)
                            now = shadow_tbl[i].ts + plan[p] + TICK_W'($urandom_range(0, 1));
                end else if (r < 75) begin
                    now = rand_ticks();
                end else if (r < 80) begin
                    now = cur - TICK_W'($urandom_range(1, 50));
                end else begin
                    cur = cur + TICK_W'($urandom_range(0, 32'(scale))) * 4;
                    now = cur;
                end
                offer_event(k.pid, k.op, k.hash, now, 1'b0, '0);
            end
        end

        // Let every result come out, then watch a while for strays.
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (NSLOTS + 8) @(posedge clk);

        $display("Sent %0d events (%0d from the directed table) under %0d window settings.",
                 events_sent, $size(PROBES), window_settings);
        $display("Saw %0d results: %0d duplicates suppressed, %0d live slots evicted.",
                 results_seen, suppressed_seen, evicted_seen);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("PASS event_dedup_window_table_unit");
        end else begin
            $display("FAIL event_dedup_window_table_unit");
        end
        $finish;
    end

endmodule
